@@ src/grace_period_combining_tree_defines.svh @@
// Assertion macros for the grace-period combining tree.
// Included by the top level; no dependencies.
`ifndef GRACE_PERIOD_COMBINING_TREE_DEFINES_SVH
`define GRACE_PERIOD_COMBINING_TREE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define GPCT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset
`define GPCT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GPCT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define GPCT_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ src/gpct_pkg.sv @@
// Shared types and fixed widths of the grace-period combining tree.
// No dependencies.
package gpct_pkg;

  localparam int CPU_W    = 4;
  localparam int NUM_IDS  = 2 ** CPU_W;
  localparam int SEQ_W    = 32;
  localparam int ONLINE_W = 16;
  localparam logic [ONLINE_W-1:0] ONLINE_RESET = '1;

  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_REPORT  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SWEEP,
    S_REQ,
    S_RD,
    S_UPD,
    S_DONE
  } state_t;

endpackage

@@ src/gpct_in_if.sv @@
// Input channel of the grace-period combining tree: request or report.
// Depends on gpct_pkg.
interface gpct_in_if import gpct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [CPU_W-1:0] cpu_id;

  modport source (output valid, output mode, output cpu_id, input ready);
  modport sink   (input valid, input mode, input cpu_id, output ready);
endinterface

@@ src/gpct_out_if.sv @@
// Result channel of the grace-period combining tree.
// Depends on gpct_pkg.
interface gpct_out_if import gpct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] current_seq;
  logic [SEQ_W-1:0] finished_seq;
  logic             period_started;
  logic             period_completed;
  logic             report_taken;

  modport source (output valid, output current_seq, output finished_seq,
                  output period_started, output period_completed,
                  output report_taken, input ready);
  modport sink   (input valid, input current_seq, input finished_seq,
                  input period_started, input period_completed,
                  input report_taken, output ready);
endinterface

@@ src/grace_period_combining_tree.sv @@
// A request without a start goes through evaluate, request and done; a request that
//   starts a period sweeps every node and CPU first; a report reads and updates a node
//   per tree level visited. One item is in flight; the next is taken after it is done.
// A new item is taken while the previous result waits at the output register.
// Reset (rst, synchronous): sequences and pending bits cleared, online mask all ones.
// Depends on gpct_pkg, gpct_in_if, gpct_out_if and the defines header.
`include "grace_period_combining_tree_defines.svh"

module grace_period_combining_tree import gpct_pkg::*; #(
  parameter int NUM_CPUS = 16,
  parameter int FANOUT   = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [ONLINE_W-1:0] cfg_wdata,
  gpct_in_if.sink             in_ch,
  gpct_out_if.source          out_ch
);

  // Tree shape, worked out at elaboration
  localparam int L0 = (NUM_CPUS + FANOUT - 1) / FANOUT;
  localparam int L1 = (L0 + FANOUT - 1) / FANOUT;
  localparam int L2 = (L1 + FANOUT - 1) / FANOUT;
  localparam int L3 = (L2 + FANOUT - 1) / FANOUT;
  localparam int NUM_LVLS = (L0 <= 1) ? 1 : (L1 <= 1) ? 2 : (L2 <= 1) ? 3 : 4;
  localparam int C1 = (NUM_LVLS > 1) ? L1 : 0;
  localparam int C2 = (NUM_LVLS > 2) ? L2 : 0;
  localparam int C3 = (NUM_LVLS > 3) ? L3 : 0;
  localparam int OFF1 = L0;
  localparam int OFF2 = OFF1 + C1;
  localparam int OFF3 = OFF2 + C2;
  localparam int NUM_NODES = OFF3 + C3;
  localparam int KID1 = ((L0 % FANOUT) == 0) ? FANOUT : (L0 % FANOUT);
  localparam int KID2 = ((L1 % FANOUT) == 0) ? FANOUT : (L1 % FANOUT);
  localparam int KID3 = ((L2 % FANOUT) == 0) ? FANOUT : (L2 % FANOUT);
  localparam logic [FANOUT-1:0] KMASK1 = {FANOUT{1'b1}} >> (FANOUT - KID1);
  localparam logic [FANOUT-1:0] KMASK2 = {FANOUT{1'b1}} >> (FANOUT - KID2);
  localparam logic [FANOUT-1:0] KMASK3 = {FANOUT{1'b1}} >> (FANOUT - KID3);

  // CPUs that can exist and be online
  localparam int NC = (NUM_CPUS < ONLINE_W) ? NUM_CPUS : ONLINE_W;
  localparam int CS_W = $clog2(NC);
  localparam logic [ONLINE_W-1:0] NC_MASK = {ONLINE_W{1'b1}} >> (ONLINE_W - NC);

  localparam int NODE_W  = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int SWEEP_N = (NUM_NODES > NC) ? NUM_NODES : NC;
  localparam int SW_W    = $clog2(SWEEP_N);
  localparam int OS_W    = ONLINE_W + FANOUT;

  // Quotient and remainder by the fanout for every CPU index
  typedef logic [NUM_IDS-1:0][CPU_W-1:0] idx_tab_t;

  function automatic idx_tab_t div_table();
    idx_tab_t t;
    for (int x = 0; x < NUM_IDS; x++) begin
      t[x] = CPU_W'(x / FANOUT);
    end
    return t;
  endfunction

  function automatic idx_tab_t mod_table();
    idx_tab_t t;
    for (int x = 0; x < NUM_IDS; x++) begin
      t[x] = CPU_W'(x % FANOUT);
    end
    return t;
  endfunction

  localparam idx_tab_t DIV_TAB = div_table();
  localparam idx_tab_t MOD_TAB = mod_table();

  state_t state, state_next;

  logic [ONLINE_W-1:0] online;
  logic [SEQ_W-1:0]    period_seq;
  logic [SEQ_W-1:0]    done_seq;
  logic [ONLINE_W-1:0] cpu_pending;

  logic             mode_q;
  logic [CPU_W-1:0] cpu_q;
  logic [SEQ_W-1:0] cseq_rd;

  logic [SW_W-1:0]   cnt;
  logic [1:0]        slvl;
  logic [OS_W-1:0]   online_shift;
  logic [1:0]        clvl;
  logic [CPU_W-1:0]  cj;
  logic [FANOUT-1:0] cbit;
  logic [NODE_W-1:0] node_addr;
  logic [FANOUT:0]   node_rd;

  logic             item_started;
  logic             item_completed;
  logic             item_taken;

  logic             out_valid;
  logic [SEQ_W-1:0] res_current;
  logic [SEQ_W-1:0] res_finished;
  logic             res_started;
  logic             res_completed;
  logic             res_taken;

  logic [FANOUT:0]  node_mem [NUM_NODES];
  logic [SEQ_W-1:0] cpu_seq_mem [NC];

  logic                in_xfer;
  logic                in_range;
  logic                idle_period;
  logic                hit;
  logic                start_go;
  logic                take_go;
  logic                load_out;
  logic [ONLINE_W-1:0] online_eff;
  logic [NODE_W-1:0]   lvl_off;
  logic [NODE_W-1:0]   caddr;
  logic                sweep_node;
  logic                sweep_last;
  logic [FANOUT-1:0]   kmask;
  logic [FANOUT-1:0]   sweep_mask;
  logic [FANOUT-1:0]   upd_mask;
  logic                upd_empty;
  logic                climb_top;
  logic                node_we;
  logic [NODE_W-1:0]   node_waddr;
  logic [FANOUT:0]     node_wdata;
  logic                cseq_we;
  logic [CS_W-1:0]     cseq_waddr;

  // Decode of the held item
  assign online_eff  = online & NC_MASK;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_range    = int'(cpu_q) < NC;
  assign idle_period = period_seq == done_seq;
  assign hit         = cpu_pending[cpu_q] && (cseq_rd == period_seq);
  assign start_go    = (state == S_EVAL) && in_range && (mode_q == MODE_REQUEST)
                       && idle_period;
  assign take_go     = (state == S_EVAL) && in_range && (mode_q == MODE_REPORT) && hit;

  // Node address of the climb position
  always_comb begin
    case (clvl)
      2'd0:    lvl_off = '0;
      2'd1:    lvl_off = NODE_W'(OFF1);
      2'd2:    lvl_off = NODE_W'(OFF2);
      default: lvl_off = NODE_W'(OFF3);
    endcase
  end
  assign caddr = lvl_off + NODE_W'(cj);

  // Sweep: node masks for the new period
  always_comb begin
    case (slvl)
      2'd0:    sweep_last = int'(cnt) == OFF1 - 1;
      2'd1:    sweep_last = int'(cnt) == OFF2 - 1;
      2'd2:    sweep_last = int'(cnt) == OFF3 - 1;
      default: sweep_last = int'(cnt) == NUM_NODES - 1;
    endcase
    case (slvl)
      2'd1:    kmask = KMASK1;
      2'd2:    kmask = KMASK2;
      default: kmask = KMASK3;
    endcase
    if (slvl == 2'd0) begin
      sweep_mask = online_shift[FANOUT-1:0];
    end else if (sweep_last) begin
      sweep_mask = kmask;
    end else begin
      sweep_mask = '1;
    end
  end
  assign sweep_node = int'(cnt) < NUM_NODES;

  // Climb: clear the child bit in the node just read
  assign upd_mask  = node_rd[FANOUT-1:0] & ~cbit;
  assign upd_empty = upd_mask == '0;
  assign climb_top = int'(clvl) == NUM_LVLS - 1;

  // Next state and memory write strobes
  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    load_out    = 1'b0;
    node_we     = 1'b0;
    node_waddr  = node_addr;
    node_wdata  = {upd_empty, upd_mask};
    cseq_we     = 1'b0;
    cseq_waddr  = cpu_q[CS_W-1:0];
    case (state)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (start_go) begin
          state_next = S_SWEEP;
        end else if (in_range && mode_q == MODE_REQUEST) begin
          state_next = S_REQ;
        end else if (take_go) begin
          state_next = S_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SWEEP: begin
        node_we    = sweep_node;
        node_waddr = cnt[NODE_W-1:0];
        node_wdata = {1'b0, sweep_mask};
        cseq_waddr = cnt[CS_W-1:0];
        cseq_we    = (int'(cnt) < NC) && online_eff[CPU_W'(cnt[CS_W-1:0])];
        if (int'(cnt) == SWEEP_N - 1) begin
          state_next = S_REQ;
        end
      end
      S_REQ: begin
        cseq_we    = 1'b1;
        state_next = S_DONE;
      end
      S_RD: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (node_rd[FANOUT]) begin
          state_next = S_DONE;
        end else begin
          node_we = 1'b1;
          if (!upd_empty || climb_top) begin
            state_next = S_DONE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || out_ch.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Period state, pending bits, online mask and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      online      <= ONLINE_RESET;
      period_seq  <= '0;
      done_seq    <= '0;
      cpu_pending <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        online <= cfg_wdata;
      end
      if (start_go) begin
        period_seq  <= period_seq + SEQ_W'(1);
        cpu_pending <= cpu_pending | online_eff;
      end
      if (take_go) begin
        cpu_pending[cpu_q] <= 1'b0;
      end
      if (state == S_REQ) begin
        cpu_pending[cpu_q] <= 1'b1;
      end
      if (state == S_UPD && !node_rd[FANOUT] && upd_empty && climb_top) begin
        done_seq <= period_seq;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item, sweep and climb registers; working flags copied to the result at load
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_q         <= in_ch.mode;
      cpu_q          <= in_ch.cpu_id;
      item_started   <= 1'b0;
      item_completed <= 1'b0;
      item_taken     <= 1'b0;
    end
    if (start_go) begin
      item_started <= 1'b1;
      cnt          <= '0;
      slvl         <= 2'd0;
      online_shift <= {{FANOUT{1'b0}}, online_eff};
    end
    if (state == S_SWEEP) begin
      cnt <= cnt + SW_W'(1);
      if (sweep_node && slvl == 2'd0) begin
        online_shift <= online_shift >> FANOUT;
      end
      if (sweep_node && sweep_last && int'(slvl) < NUM_LVLS - 1) begin
        slvl <= slvl + 2'd1;
      end
    end
    if (take_go) begin
      item_taken <= 1'b1;
      clvl       <= 2'd0;
      cj         <= DIV_TAB[cpu_q];
      cbit       <= FANOUT'(1) << MOD_TAB[cpu_q];
    end
    if (state == S_RD) begin
      node_addr <= caddr;
    end
    if (state == S_UPD && !node_rd[FANOUT] && upd_empty) begin
      if (climb_top) begin
        item_completed <= 1'b1;
      end else begin
        clvl <= clvl + 2'd1;
        cj   <= DIV_TAB[cj];
        cbit <= FANOUT'(1) << MOD_TAB[cj];
      end
    end
    if (load_out) begin
      res_current   <= period_seq;
      res_finished  <= done_seq;
      res_started   <= item_started;
      res_completed <= item_completed;
      res_taken     <= item_taken;
    end
  end

  // Node memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (state == S_RD) begin
      node_rd <= node_mem[caddr];
    end
  end

  // Per-CPU sequence memory, read when an item transfers
  always_ff @(posedge clk) begin
    if (cseq_we) begin
      cpu_seq_mem[cseq_waddr] <= period_seq;
    end
    if (in_xfer) begin
      cseq_rd <= cpu_seq_mem[in_ch.cpu_id[CS_W-1:0]];
    end
  end

  // Result port
  assign out_ch.valid            = out_valid;
  assign out_ch.current_seq      = res_current;
  assign out_ch.finished_seq     = res_finished;
  assign out_ch.period_started   = res_started;
  assign out_ch.period_completed = res_completed;
  assign out_ch.report_taken     = res_taken;

  // Checks
  `GPCT_ASSERT_NXT(a_start_bumps_seq, clk, rst, start_go, period_seq == $past(period_seq) + SEQ_W'(1), "start did not advance the sequence")
  `GPCT_ASSERT_IMP(a_sweep_in_period, clk, rst, state == S_SWEEP, period_seq != done_seq, "sweep outside a running period")
  `GPCT_ASSERT_IMP(a_climb_in_tree, clk, rst, state == S_UPD, int'(clvl) < NUM_LVLS, "climb left the tree")
  `GPCT_ASSERT_IMP(a_done_matches, clk, rst, out_valid && res_completed, res_finished == res_current, "completion without matching sequences")
  `GPCT_ASSERT_IMP(a_flags_exclusive, clk, rst, out_valid, !(res_started && res_taken), "start and report in one result")

endmodule

@@ sim/grace_period_combining_tree_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for grace_period_combining_tree: directed and random
// requests and quiescent reports, each result checked against a local tracker.
// Depends on gpct_pkg, gpct_in_if, gpct_out_if and the RTL of the block.
module grace_period_combining_tree_tb;
  import gpct_pkg::*;

  localparam int TREE_FANOUT = 4;
  localparam int LEAF_NODES  = NUM_IDS / TREE_FANOUT;
  localparam int ROOT_NODE   = LEAF_NODES;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    logic [SEQ_W-1:0] cur_seq;
    logic [SEQ_W-1:0] fin_seq;
    logic             started;
    logic             completed;
    logic             taken;
  } gp_outcome_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [ONLINE_W-1:0] cfg_wdata;

  gpct_in_if  in_ch();
  gpct_out_if out_ch();

  grace_period_combining_tree dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Tracker copy of the block state
  logic [ONLINE_W-1:0]    online_now;
  logic [SEQ_W-1:0]       period_no;
  logic [SEQ_W-1:0]       closed_no;
  logic [NUM_IDS-1:0]     cpu_wait;
  logic [SEQ_W-1:0]       cpu_tag [NUM_IDS];
  logic [TREE_FANOUT-1:0] node_bits [LEAF_NODES+1];
  logic                   node_fin [LEAF_NODES+1];

  gp_outcome_t gp_outcomes [$];

  bit steady_flow;
  int mismatch_cnt;
  int items_sent;
  int results_seen;
  int starts_seen;
  int completions_seen;
  int reports_seen;
  int quiet_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_tracker();
    online_now = ONLINE_RESET;
    period_no  = '0;
    closed_no  = '0;
    cpu_wait   = '0;
    for (int c = 0; c < NUM_IDS; c++) cpu_tag[c] = '0;
    for (int n = 0; n <= LEAF_NODES; n++) begin
      node_bits[n] = '0;
      node_fin[n]  = 1'b0;
    end
  endfunction

  // Load leaf masks from the online CPUs, the root from the leaf count
  function automatic void open_period();
    period_no++;
    for (int j = 0; j < LEAF_NODES; j++) begin
      node_bits[j] = online_now[j*TREE_FANOUT +: TREE_FANOUT];
      node_fin[j]  = 1'b0;
    end
    node_bits[ROOT_NODE] = '1;
    node_fin[ROOT_NODE]  = 1'b0;
    for (int c = 0; c < NUM_IDS; c++) begin
      if (online_now[c]) begin
        cpu_tag[c]  = period_no;
        cpu_wait[c] = 1'b1;
      end
    end
  endfunction

  // Apply one request or report and return the result it yields
  function automatic gp_outcome_t advance_tracker(logic md, logic [CPU_W-1:0] id);
    gp_outcome_t r;
    int leaf;
    r    = '0;
    leaf = id / TREE_FANOUT;
    if (md == MODE_REQUEST) begin
      if (period_no == closed_no) begin
        open_period();
        r.started = 1'b1;
      end
      cpu_tag[id]  = period_no;
      cpu_wait[id] = 1'b1;
    end else if (cpu_wait[id] && cpu_tag[id] == period_no) begin
      cpu_wait[id] = 1'b0;
      r.taken      = 1'b1;
      // Climb only through nodes that are still open
      if (!node_fin[leaf]) begin
        node_bits[leaf][id % TREE_FANOUT] = 1'b0;
        if (node_bits[leaf] == '0) begin
          node_fin[leaf] = 1'b1;
          if (!node_fin[ROOT_NODE]) begin
            node_bits[ROOT_NODE][leaf] = 1'b0;
            if (node_bits[ROOT_NODE] == '0) begin
              node_fin[ROOT_NODE] = 1'b1;
              closed_no           = period_no;
              r.completed         = 1'b1;
            end
          end
        end
      end
    end
    r.cur_seq = period_no;
    r.fin_seq = closed_no;
    return r;
  endfunction

  // Prefer CPUs whose report would be taken, so periods keep closing
  function automatic logic [CPU_W-1:0] pick_reporter();
    int live [$];
    for (int c = 0; c < NUM_IDS; c++) begin
      if (cpu_wait[c] && cpu_tag[c] == period_no) live.push_back(c);
    end
    if (live.size() != 0 && $urandom_range(99) < 85)
      return CPU_W'(live[$urandom_range(live.size() - 1)]);
    return CPU_W'($urandom_range(NUM_IDS - 1));
  endfunction

  function automatic void check_field(string name, logic [SEQ_W-1:0] want,
                                      logic [SEQ_W-1:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("MISMATCH result %0d %s: expected %0d, got %0d",
                 results_seen, name, want, got);
    end
  endfunction

  // Drive one item, hold it until the transfer, then record its outcome
  task automatic send_item(input logic md, input logic [CPU_W-1:0] id);
    int gap;
    gap = (steady_flow || $urandom_range(99) >= 25) ? 0 : $urandom_range(1, 4);
    if (gap > 0) begin
      in_ch.valid  <= 1'b0;
      in_ch.mode   <= 1'($urandom_range(1));
      in_ch.cpu_id <= CPU_W'($urandom_range(NUM_IDS - 1));
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= md;
    in_ch.cpu_id <= id;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    gp_outcomes.push_back(advance_tracker(md, id));
    items_sent++;
  endtask

  // Drop valid and hold until every outstanding result has come back
  task automatic await_quiet();
    in_ch.valid <= 1'b0;
    while (gp_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_online(input logic [ONLINE_W-1:0] mask);
    await_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we     <= 1'b0;
    online_now  = mask;
  endtask

  // One online CPU per leaf; an offline requester reports into a closed leaf
  task automatic test_closed_leaf();
    write_online(16'h1111);
    send_item(MODE_REQUEST, 4'd0);
    send_item(MODE_REQUEST, 4'd1);
    send_item(MODE_REPORT, 4'd0);
    send_item(MODE_REPORT, 4'd1);
    send_item(MODE_REPORT, 4'd4);
    send_item(MODE_REPORT, 4'd8);
    send_item(MODE_REPORT, 4'd12);
    send_item(MODE_REPORT, 4'd12);
  endtask

  // No CPU online: requesters alone drive the tree, then a stale report
  task automatic test_all_offline();
    write_online(16'h0000);
    send_item(MODE_REQUEST, 4'd3);
    send_item(MODE_REQUEST, 4'd2);
    send_item(MODE_REPORT, 4'd2);
    send_item(MODE_REQUEST, 4'd5);
    send_item(MODE_REPORT, 4'd5);
    send_item(MODE_REQUEST, 4'd10);
    send_item(MODE_REPORT, 4'd10);
    send_item(MODE_REQUEST, 4'd15);
    send_item(MODE_REPORT, 4'd15);
    send_item(MODE_REQUEST, 4'd7);
    send_item(MODE_REPORT, 4'd3);
    send_item(MODE_REPORT, 4'd7);
  endtask

  // Random traffic under one online mask, with a full pause halfway
  task automatic test_random_phase(input logic [ONLINE_W-1:0] mask, input int count,
                                   input bit no_idle);
    write_online(mask);
    steady_flow = no_idle;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) await_quiet();
      if ($urandom_range(99) < 30)
        send_item(MODE_REQUEST, CPU_W'($urandom_range(NUM_IDS - 1)));
      else
        send_item(MODE_REPORT, pick_reporter());
    end
    steady_flow = 1'b0;
  endtask

  // Result sink with random backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady_flow || ($urandom_range(99) >= 25);
    end
  end

  // Compare each result transfer with the oldest outcome
  always @(posedge clk) begin
    gp_outcome_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      starts_seen      += out_ch.period_started;
      completions_seen += out_ch.period_completed;
      reports_seen     += out_ch.report_taken;
      if (gp_outcomes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("MISMATCH result %0d arrived with nothing outstanding", results_seen);
      end else begin
        want = gp_outcomes.pop_front();
        check_field("current_seq", want.cur_seq, out_ch.current_seq);
        check_field("finished_seq", want.fin_seq, out_ch.finished_seq);
        check_field("period_started", SEQ_W'(want.started), SEQ_W'(out_ch.period_started));
        check_field("period_completed", SEQ_W'(want.completed),
                    SEQ_W'(out_ch.period_completed));
        check_field("report_taken", SEQ_W'(want.taken), SEQ_W'(out_ch.report_taken));
      end
    end
  end

  // Watchdog: end the run when transfers stop for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles without a transfer", quiet_cycles);
      $display("grace_period_combining_tree test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence
  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_REQUEST;
    in_ch.cpu_id = '0;
    steady_flow  = 1'b0;
    quiet_cycles = 0;
    clear_tracker();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_closed_leaf();
    test_all_offline();
    test_random_phase(16'hFFFF, 200, 1'b0);
    test_random_phase(16'h0000, 200, 1'b0);
    test_random_phase(16'h8001, 200, 1'b1);
    test_random_phase(ONLINE_W'($urandom), 200, 1'b0);
    test_random_phase(16'h00F0, 200, 1'b0);
    test_random_phase(ONLINE_W'($urandom), 200, 1'b0);

    // Let stray results show up before the verdict
    await_quiet();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d requests and reports over 8 online masks; checked %0d results",
             items_sent, results_seen);
    $display("Periods started %0d, completed %0d, reports taken %0d, mismatches %0d",
             starts_seen, completions_seen, reports_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && gp_outcomes.size() == 0) begin
      $display("grace_period_combining_tree test passed");
    end else begin
      $display("grace_period_combining_tree test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/gpct_pkg.sv
src/gpct_in_if.sv
src/gpct_out_if.sv
src/grace_period_combining_tree.sv
sim/grace_period_combining_tree_tb.sv
